// ===== rtl/spl_pkg.sv =====
// spl_pkg: shared types and constants of the sorted priority list unit
// used by spl_cell and sorted_priority_list_unit; no dependencies
package spl_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned TagW        = 16;
  localparam int unsigned PrioW       = 16;
  localparam int unsigned StatusW     = 2;

  // status codes carried on the result tuser
  localparam logic [StatusW-1:0] StEntry    = 2'd0;
  localparam logic [StatusW-1:0] StAccepted = 2'd1;
  localparam logic [StatusW-1:0] StFull     = 2'd2;
  localparam logic [StatusW-1:0] StEmpty    = 2'd3;

  // input kind codes carried on the input tuser
  localparam logic KindInsert = 1'b0;
  localparam logic KindReview = 1'b1;

  typedef struct packed {
    logic                    valid;
    logic [TagW-1:0]         tag;
    logic signed [PrioW-1:0] prio;
  } slot_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic                    insert;
    logic                    rotate;
    logic [TagW-1:0]         tag;
    logic signed [PrioW-1:0] prio;
  } cell_ctrl_t;

endpackage

// ===== rtl/spl_cell.sv =====
// spl_cell: one compare-and-shift cell of the sorted list chain
// depends on spl_pkg
module spl_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spl_pkg::cell_ctrl_t ctrl_i,
  input  logic               prev_place_i,  // left neighbour takes the new entry or shifts
  input  spl_pkg::slot_t     prev_slot_i,
  input  spl_pkg::slot_t     next_slot_i,
  input  spl_pkg::slot_t     head_slot_i,
  output logic               place_o,
  output spl_pkg::slot_t     slot_o
);

  spl_pkg::slot_t slot_q, slot_d;

  // this cell moves up on insert: empty, or holds a strictly higher priority
  assign place_o = !slot_q.valid || (slot_q.prio > ctrl_i.prio);

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.insert && place_o) begin
      if (prev_place_i) begin
        slot_d = prev_slot_i;
      end else begin
        slot_d.valid = 1'b1;
        slot_d.tag   = ctrl_i.tag;
        slot_d.prio  = ctrl_i.prio;
      end
    end else if (ctrl_i.rotate) begin
      // pull from the right; the tail of the valid run wraps in the head
      if (next_slot_i.valid) begin
        slot_d = next_slot_i;
      end else if (slot_q.valid) begin
        slot_d = head_slot_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// ===== rtl/sorted_priority_list_unit.sv =====
// sorted_priority_list_unit: top level of the sorted priority list
// depends on spl_pkg and spl_cell
//
// usage
//  - input stream: tuser selects insert (0) or review (1); tdata carries the
//    tag and the signed priority of an entry to insert
//  - result stream: tdata carries tag and priority of an entry read out,
//    tuser the status, tlast marks the final result of an input transfer
//  - the list lives in a row of CAPACITY cells kept in ascending priority;
//    an insert is placed by every cell comparing against the new priority
//    and shifting up by one together; equal priorities keep
//    arrival order, and an insert into a full list is rejected
//  - insert: one status result in the cycle after the transfer; a new item is
//    taken every cycle while the result register drains
//  - review: the row rotates towards cell 0 once per result; entries leave via
//    the read state one per cycle while the receiver takes them (one empty-status
//    result for an empty list, in the cycle after); the row ends in its original
//    order and no input is taken until the last entry is in the result register
//  - a stalled receiver holds the result register and freezes the rotation
//  - reset empties the list and drops any result in flight
module sorted_priority_list_unit #(
  parameter int unsigned CAPACITY = spl_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] entry_tag, [31:16] entry_priority
  input  logic        s_axis_tuser,   // [0] kind
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] out_tag, [31:16] out_priority
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  state_e         state_q;
  logic [CntW-1:0] count_q;   // stored entries
  logic [CntW-1:0] remain_q;  // entries still to read out

  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [1:0]  out_status_q;
  logic        out_last_q;

  spl_pkg::cell_ctrl_t ctrl;
  spl_pkg::slot_t      slots [CAPACITY];
  logic                place [CAPACITY];

  logic out_free;
  logic in_xfer;
  logic full;
  logic is_insert;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign full      = (count_q == CntW'(CAPACITY));
  assign is_insert = (s_axis_tuser == spl_pkg::KindInsert);

  // broadcast to the chain
  always_comb begin
    ctrl.insert = in_xfer && is_insert && !full;
    ctrl.rotate = (state_q == StRead) && out_free;
    ctrl.tag    = s_axis_tdata[15:0];
    ctrl.prio   = s_axis_tdata[31:16];
  end

  // the chain of cells; cell 0 holds the lowest priority
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic           prev_place;
    spl_pkg::slot_t prev_slot;
    spl_pkg::slot_t next_slot;

    if (i == 0) begin : g_first
      assign prev_place = 1'b0;
      assign prev_slot  = '0;
    end else begin : g_inner
      assign prev_place = place[i-1];
      assign prev_slot  = slots[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_notlast
      assign next_slot = slots[i+1];
    end

    spl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_place_i (prev_place),
      .prev_slot_i  (prev_slot),
      .next_slot_i  (next_slot),
      .head_slot_i  (slots[0]),
      .place_o      (place[i]),
      .slot_o       (slots[i])
    );
  end

  // sequencer, entry count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      remain_q     <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_status_q <= spl_pkg::StEntry;
      out_last_q   <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            out_data_q  <= '0;
            out_last_q  <= 1'b1;
            if (is_insert) begin
              out_valid_q <= 1'b1;
              if (full) begin
                out_status_q <= spl_pkg::StFull;
              end else begin
                out_status_q <= spl_pkg::StAccepted;
                count_q      <= count_q + 1'b1;
              end
            end else if (count_q == '0) begin
              out_valid_q  <= 1'b1;
              out_status_q <= spl_pkg::StEmpty;
            end else begin
              // review: results come from the rotation
              out_valid_q <= 1'b0;
              remain_q    <= count_q;
              state_q     <= StRead;
            end
          end else if (m_axis_tready) begin
            out_valid_q <= 1'b0;
          end
        end
        StRead: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_data_q   <= {slots[0].prio, slots[0].tag};
            out_status_q <= spl_pkg::StEntry;
            out_last_q   <= (remain_q == CntW'(1));
            remain_q     <= remain_q - 1'b1;
            if (remain_q == CntW'(1)) begin
              state_q <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== tb/sorted_priority_list_unit_tb.sv =====
// sorted_priority_list_unit_tb: self-checking testbench of the sorted priority list unit
// needs spl_pkg and sorted_priority_list_unit; drives both streams with random pacing
// and checks every result transfer against an in-bench model of the sorted list
module sorted_priority_list_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Capacity    = spl_pkg::DefCapacity;
  localparam int unsigned RandomItems = 470;
  localparam int unsigned QuietLimit  = 2000;        // cycles without any transfer
  localparam int unsigned DrainCycles = 3 * Capacity;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned NumDirected = 24;

  typedef struct packed {
    logic [spl_pkg::TagW-1:0]         tag;
    logic signed [spl_pkg::PrioW-1:0] prio;
  } list_entry_t;

  typedef struct packed {
    logic [spl_pkg::TagW-1:0]         tag;
    logic signed [spl_pkg::PrioW-1:0] prio;
    logic [spl_pkg::StatusW-1:0]      status;
    logic                             last;
  } readout_t;

  // one input transfer; typed rows carry their single status result inline
  typedef struct packed {
    logic                         kind;
    logic [spl_pkg::TagW-1:0]     tag;
    logic [spl_pkg::PrioW-1:0]    prio;
    logic                         typed;
    logic [spl_pkg::StatusW-1:0]  typed_status;
  } stim_row_t;

  typedef enum int unsigned {RxOpen, RxRandom, RxCadence, RxBursty} rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] entry_tag, [31:16] entry_priority
  logic        s_axis_tuser;   // [0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] out_tag, [31:16] out_priority
  logic [1:0]  m_axis_tuser;   // [1:0] status
  logic        m_axis_tlast;

  // in-bench copy of the list, ascending priority, arrival order among equals
  list_entry_t sorted_entries [$];
  // results still owed by the block, oldest first
  readout_t    owed_readouts [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  // directed part: extremes, equal priorities at head, middle and tail,
  // empty review, ignored insert fields on a review, and inserts into a full list
  stim_row_t directed_rows [NumDirected] = '{
    '{spl_pkg::KindReview, 16'h0000, 16'h0000, 1'b1, spl_pkg::StEmpty},    // before any insert
    '{spl_pkg::KindInsert, 16'hffff, 16'h7fff, 1'b1, spl_pkg::StAccepted}, // highest priority
    '{spl_pkg::KindInsert, 16'h0000, 16'h8000, 1'b1, spl_pkg::StAccepted}, // lowest priority
    '{spl_pkg::KindReview, 16'h0000, 16'h0000, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'h1234, 16'h0000, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'h5555, 16'h0000, 1'b0, spl_pkg::StEntry},    // same, goes after
    '{spl_pkg::KindInsert, 16'haaaa, 16'h7fff, 1'b0, spl_pkg::StEntry},    // same as the tail
    '{spl_pkg::KindInsert, 16'h0001, 16'h8000, 1'b0, spl_pkg::StEntry},    // same as the head
    '{spl_pkg::KindReview, 16'hbeef, 16'h4321, 1'b0, spl_pkg::StEntry},    // fields ignored
    '{spl_pkg::KindInsert, 16'h8000, 16'hffff, 1'b0, spl_pkg::StEntry},    // -1
    '{spl_pkg::KindInsert, 16'h7fff, 16'h0001, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'h0f0f, 16'h4000, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'hf0f0, 16'hc000, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'h3c3c, 16'h0000, 1'b0, spl_pkg::StEntry},    // third at zero
    '{spl_pkg::KindInsert, 16'hc3c3, 16'h0064, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'h6666, 16'hff9c, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindReview, 16'h0000, 16'h0000, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'h9999, 16'h7ffe, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'h2222, 16'h8001, 1'b0, spl_pkg::StEntry},
    '{spl_pkg::KindInsert, 16'hbbbb, 16'h0005, 1'b0, spl_pkg::StEntry},    // list now full
    '{spl_pkg::KindReview, 16'h0000, 16'h0000, 1'b0, spl_pkg::StEntry},    // full readout
    '{spl_pkg::KindInsert, 16'h4444, 16'h0000, 1'b1, spl_pkg::StFull},
    '{spl_pkg::KindInsert, 16'hffff, 16'h8000, 1'b1, spl_pkg::StFull},
    '{spl_pkg::KindReview, 16'hffff, 16'hffff, 1'b0, spl_pkg::StEntry}
  };

  sorted_priority_list_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // updates the list copy for one accepted item and, if asked, queues what it owes
  task automatic apply_list_op(input logic kind, input logic [spl_pkg::TagW-1:0] tag,
                               input logic signed [spl_pkg::PrioW-1:0] prio,
                               input bit queue_results);
    int unsigned pos;
    list_entry_t entry;
    readout_t    res;
    res = '0;
    res.last = 1'b1;
    if (kind == spl_pkg::KindInsert) begin
      if (sorted_entries.size() >= Capacity) begin
        res.status = spl_pkg::StFull;
      end else begin
        // walk past every entry of lower or equal priority
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= prio) pos++;
        entry.tag  = tag;
        entry.prio = prio;
        sorted_entries.insert(pos, entry);
        res.status = spl_pkg::StAccepted;
      end
      if (queue_results) owed_readouts.push_back(res);
    end else if (sorted_entries.size() == 0) begin
      res.status = spl_pkg::StEmpty;
      if (queue_results) owed_readouts.push_back(res);
    end else if (queue_results) begin
      foreach (sorted_entries[i]) begin
        res.tag    = sorted_entries[i].tag;
        res.prio   = sorted_entries[i].prio;
        res.status = spl_pkg::StEntry;
        res.last   = (i == sorted_entries.size() - 1);
        owed_readouts.push_back(res);
      end
    end
  endtask

  // pacing of the sender: bursts of random length, random gaps, now and then a long run
  int unsigned burst_left = 0;

  task automatic send_item(input stim_row_t row);
    int unsigned gap;
    readout_t    res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.kind;
    s_axis_tdata  <= {row.prio, row.tag};
    do @(posedge clk_i); while (!s_axis_tready);
    // transfer taken at this edge
    if (row.typed) begin
      res        = '0;
      res.status = row.typed_status;
      res.last   = 1'b1;
      owed_readouts.push_back(res);
      apply_list_op(row.kind, row.tag, row.prio, 1'b0);
    end else begin
      apply_list_op(row.kind, row.tag, row.prio, 1'b1);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= $urandom;   // junk while idle
        s_axis_tuser  <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin : stimulus
    stim_row_t row;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = spl_pkg::KindInsert;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // the list stays full from here on: reviews read all of it, inserts bounce
    for (int k = 0; k < RandomItems; k++) begin
      row.kind         = ($urandom_range(0, 9) < 4) ? spl_pkg::KindReview : spl_pkg::KindInsert;
      row.tag          = spl_pkg::TagW'($urandom);
      row.prio         = spl_pkg::PrioW'($urandom);
      row.typed        = 1'b0;
      row.typed_status = spl_pkg::StEntry;
      send_item(row);
    end
    s_axis_tvalid <= 1'b0;

    while (owed_readouts.size() != 0) @(posedge clk_i);
    // catch anything extra the block might still send
    repeat (DrainCycles) @(posedge clk_i);

    if (owed_readouts.size() != 0) begin
      $display("%0d expected results never arrived", owed_readouts.size());
    end
    if (mismatch_count == 0 && owed_readouts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // receiver back-pressure: modes of random length, including open stretches
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned phase;
    int unsigned stall_left;
    mode          = RxOpen;
    mode_left     = 0;
    phase         = 0;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(30, 200);
      end
      mode_left--;
      phase++;
      case (mode)
        RxOpen: begin
          m_axis_tready <= 1'b1;
        end
        RxRandom: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        RxCadence: begin
          m_axis_tready <= ((phase % 5) < 3);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    readout_t got;
    readout_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.tag    = m_axis_tdata[15:0];
      got.prio   = m_axis_tdata[31:16];
      got.status = m_axis_tuser;
      got.last   = m_axis_tlast;
      if (owed_readouts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("unexpected result: tag %h prio %0d status %0d last %b",
                   got.tag, got.prio, got.status, got.last);
        end
      end else begin
        want = owed_readouts.pop_front();
        if (got.tag !== want.tag || got.prio !== want.prio ||
            got.status !== want.status || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("mismatch: expected tag %h prio %0d status %0d last %b,",
                     want.tag, want.prio, want.status, want.last,
                     " got tag %h prio %0d status %0d last %b",
                     got.tag, got.prio, got.status, got.last);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either stream
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("timeout after %0d cycles without a transfer", QuietLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
